@@ src/chbd_pkg.sv @@
package chbd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // decoder phase
    localparam logic [2:0] PH_SIZE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_TCR  = 3'd2;
    localparam logic [2:0] PH_TLF  = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    // size line parse step
    localparam logic [2:0] ST_LEAD = 3'd0;
    localparam logic [2:0] ST_SIGN = 3'd1;
    localparam logic [2:0] ST_ZERO = 3'd2;
    localparam logic [2:0] ST_ZX   = 3'd3;
    localparam logic [2:0] ST_DIG  = 3'd4;
    localparam logic [2:0] ST_END  = 3'd5;

    // result kind
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] step;
        logic       negative;
        logic       cr_pending;
    } t_ctrl;

    localparam t_ctrl CTRL_RESET = '{
        phase:      PH_SIZE,
        step:       ST_LEAD,
        negative:   1'b0,
        cr_pending: 1'b0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       done;
        logic       err;
        logic       more;
    } t_result;

endpackage

@@ src/chbd_step.sv @@
module chbd_step #(
    parameter int SIZE_WIDTH = chbd_pkg::SIZE_WIDTH_DEF
) (
    input  chbd_pkg::t_ctrl         i_ctrl,
    input  logic [SIZE_WIDTH-1:0]   i_chunk,
    input  logic                    i_start,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output chbd_pkg::t_ctrl         o_ctrl,
    output logic [SIZE_WIDTH-1:0]   o_chunk,
    output chbd_pkg::t_result       o_result
);

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    chbd_pkg::t_ctrl       cur;
    chbd_pkg::t_ctrl       nxt;
    logic [SIZE_WIDTH-1:0] chunk_c;
    logic [SIZE_WIDTH-1:0] chunk_n;
    logic [SIZE_WIDTH-1:0] chunk_acc;
    logic [SIZE_WIDTH-1:0] chunk_dec;
    logic [4:0]            hx;
    logic [2:0]            step_p;
    logic                  blank;
    logic [1:0]            kind;
    logic [7:0]            pay;
    logic                  done;
    logic                  err;

    always_comb begin
        cur     = i_start ? chbd_pkg::CTRL_RESET : i_ctrl;
        chunk_c = i_start ? '0 : i_chunk;
        nxt     = cur;
        chunk_n = chunk_c;
        kind    = chbd_pkg::KIND_FRAME;
        pay     = 8'd0;
        hx      = hex_digit(i_byte);
        blank   = (i_byte == chbd_pkg::CH_SPACE) || (i_byte == chbd_pkg::CH_TAB) ||
                  (i_byte == chbd_pkg::CH_LF)    || (i_byte == chbd_pkg::CH_VT)  ||
                  (i_byte == chbd_pkg::CH_FF)    || (i_byte == chbd_pkg::CH_CR);
        // saturate once any of the top nibble is set
        chunk_acc = (|chunk_c[SIZE_WIDTH-1:SIZE_WIDTH-4]) ? {SIZE_WIDTH{1'b1}}
                                                          : {chunk_c[SIZE_WIDTH-5:0], hx[3:0]};
        chunk_dec = (chunk_c != '0) ? chunk_c - {{(SIZE_WIDTH-1){1'b0}}, 1'b1} : chunk_c;
        // a held CR that is not followed by LF acts as a blank inside the line
        step_p  = (cur.cr_pending && cur.step != chbd_pkg::ST_LEAD) ? chbd_pkg::ST_END
                                                                    : cur.step;

        unique case (cur.phase)
            chbd_pkg::PH_SIZE: begin
                if (cur.cr_pending && i_byte == chbd_pkg::CH_LF) begin
                    if (chunk_c == '0) begin
                        nxt.phase = chbd_pkg::PH_DONE;
                    end else if (cur.negative) begin
                        nxt.phase = chbd_pkg::PH_ERR;
                    end else begin
                        nxt.phase = chbd_pkg::PH_DATA;
                    end
                    nxt.step       = chbd_pkg::ST_LEAD;
                    nxt.negative   = 1'b0;
                    nxt.cr_pending = 1'b0;
                end else begin
                    nxt.step       = step_p;
                    nxt.cr_pending = 1'b0;
                    if (i_byte == chbd_pkg::CH_CR) begin
                        nxt.cr_pending = 1'b1;
                    end else begin
                        unique case (step_p) inside
                            chbd_pkg::ST_LEAD, chbd_pkg::ST_SIGN: begin
                                if (step_p == chbd_pkg::ST_LEAD && blank) begin
                                    nxt.step = step_p;
                                end else if (step_p == chbd_pkg::ST_LEAD &&
                                             (i_byte == chbd_pkg::CH_PLUS ||
                                              i_byte == chbd_pkg::CH_MINUS)) begin
                                    nxt.negative = (i_byte == chbd_pkg::CH_MINUS);
                                    nxt.step     = chbd_pkg::ST_SIGN;
                                end else if (i_byte == chbd_pkg::CH_ZERO) begin
                                    nxt.step = chbd_pkg::ST_ZERO;
                                end else if (hx[4]) begin
                                    chunk_n  = chunk_acc;
                                    nxt.step = chbd_pkg::ST_DIG;
                                end else begin
                                    nxt.step = chbd_pkg::ST_END;
                                end
                            end
                            chbd_pkg::ST_ZERO: begin
                                if (i_byte == chbd_pkg::CH_LOW_X ||
                                    i_byte == chbd_pkg::CH_UP_X) begin
                                    nxt.step = chbd_pkg::ST_ZX;
                                end else if (hx[4]) begin
                                    chunk_n  = chunk_acc;
                                    nxt.step = chbd_pkg::ST_DIG;
                                end else begin
                                    nxt.step = chbd_pkg::ST_END;
                                end
                            end
                            chbd_pkg::ST_ZX, chbd_pkg::ST_DIG: begin
                                if (hx[4]) begin
                                    chunk_n  = chunk_acc;
                                    nxt.step = chbd_pkg::ST_DIG;
                                end else begin
                                    nxt.step = chbd_pkg::ST_END;
                                end
                            end
                            default: begin
                                nxt.step = step_p;
                            end
                        endcase
                    end
                end
            end
            chbd_pkg::PH_DATA: begin
                kind    = chbd_pkg::KIND_PAYLOAD;
                pay     = i_byte;
                chunk_n = chunk_dec;
                if (chunk_dec == '0) begin
                    nxt.phase = chbd_pkg::PH_TCR;
                end
            end
            chbd_pkg::PH_TCR: begin
                nxt.phase = (i_byte == chbd_pkg::CH_CR) ? chbd_pkg::PH_TLF : chbd_pkg::PH_ERR;
            end
            chbd_pkg::PH_TLF: begin
                if (i_byte == chbd_pkg::CH_LF) begin
                    nxt     = chbd_pkg::CTRL_RESET;
                    chunk_n = '0;
                end else begin
                    nxt.phase = chbd_pkg::PH_ERR;
                end
            end
            default: begin
                kind = chbd_pkg::KIND_IGNORED;
            end
        endcase

        done = (nxt.phase == chbd_pkg::PH_DONE);
        err  = (nxt.phase == chbd_pkg::PH_ERR);
    end

    assign o_ctrl           = nxt;
    assign o_chunk          = chunk_n;
    assign o_result.kind    = kind;
    assign o_result.payload = pay;
    assign o_result.done    = done;
    assign o_result.err     = err;
    assign o_result.more    = i_last && !done && !err;

endmodule

@@ src/http_chunked_body_decoder.sv @@
// Chunked transfer decoder for an HTTP/1.1 message body.
//
// Input channel (s_axis): one body byte per item. tdata carries the byte,
// tlast marks the last byte of a received block, tuser[0] set clears all
// decoder state before the byte is handled (start of a new body).
// Output channel (m_axis): exactly one result item per input item, in order.
// tuser is the kind (0 framing byte, 1 payload byte, 2 ignored after done or
// error); tdata holds the payload byte, message done, sticky framing error
// and the awaiting-more flag (set only on a block's last byte).
//
// Pipeline: input register, one pass of decode logic, result register. An
// accepted item waits in the input register, and its result is loaded into
// the result register once that register is free; m_axis_tvalid is driven
// from the result register. One item per cycle is sustained while the receiver
// does not stall; the decode pass is the only logic between registers.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and s_axis_tready drops; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties both stages and returns the
// decoder to the start of a size line with a zero chunk count.
module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH = chbd_pkg::SIZE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [chbd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic [chbd_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // [0] start_message
    input  logic                             s_axis_tlast,  // block_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] payload_byte, [8] message_done, [9] framing_error,
    // [10] awaiting_more, [15:11] zero
    output logic [chbd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [chbd_pkg::M_TUSER_W-1:0]   m_axis_tuser   // [1:0] out_kind
);

    // input stage
    logic       r_in_valid;
    logic       r_in_start;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // decoder state
    chbd_pkg::t_ctrl       r_ctrl;
    logic [SIZE_WIDTH-1:0] r_chunk;

    // result stage
    logic              r_out_valid;
    chbd_pkg::t_result r_out;

    chbd_pkg::t_ctrl       n_ctrl;
    logic [SIZE_WIDTH-1:0] n_chunk;
    chbd_pkg::t_result     n_out;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    chbd_step #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_step (
        .i_ctrl   (r_ctrl),
        .i_chunk  (r_chunk),
        .i_start  (r_in_start),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_ctrl   (n_ctrl),
        .o_chunk  (n_chunk),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_start <= s_axis_tuser[0];
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= chbd_pkg::CTRL_RESET;
            r_chunk <= '0;
        end else if (advance) begin
            r_ctrl  <= n_ctrl;
            r_chunk <= n_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.more, r_out.err, r_out.done, r_out.payload};

endmodule

@@ src/chbd_checker.sv @@
module chbd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [chbd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic [chbd_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    // done and error are distinct end states
    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("done and error both set");

    // a payload byte never ends the message or raises the error
    a_payload_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == chbd_pkg::KIND_PAYLOAD)
            |-> (!m_axis_tdata[8] && !m_axis_tdata[9]))
        else $error("payload item with done or error");

    // ignored bytes only follow done or error
    a_ignored_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == chbd_pkg::KIND_IGNORED)
            |-> (m_axis_tdata[8] || m_axis_tdata[9]))
        else $error("ignored item while message open");

    // awaiting-more only while the message is still open
    a_more_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10])
            |-> (!m_axis_tdata[8] && !m_axis_tdata[9] &&
                 (m_axis_tuser == chbd_pkg::KIND_PAYLOAD || m_axis_tuser == chbd_pkg::KIND_FRAME)))
        else $error("awaiting more on closed message");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
